// File: rtl/umls_pkg.sv
package umls_pkg;

  localparam int MaxLists   = 8;
  localparam int MaxListLen = 256;
  localparam int KeyWidth   = 32;
  localparam int StoreDepth = MaxLists * MaxListLen;

  localparam int LidW  = $clog2(MaxLists);
  localparam int SlotW = $clog2(MaxListLen);
  localparam int LenW  = $clog2(MaxListLen + 1);
  localparam int AddrW = $clog2(StoreDepth);
  localparam int CntW  = $clog2(StoreDepth + 1);
  localparam int PtAddrW = AddrW + LidW;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_BUILD  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         list_id;
    logic signed [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  list_no;
    logic [8:0]  position;
    logic [11:0] distinct_count;
    logic        last;
  } out_word_t;

  // store-side request from the sequencer
  typedef struct packed {
    logic             ls_we;
    logic [AddrW-1:0] ls_addr;
    logic             uk_we;
    logic [AddrW-1:0] uk_addr;
    logic             pt_we;
    logic [PtAddrW-1:0] pt_addr;
    logic [KeyWidth-1:0] wkey;
    logic [LenW-1:0]  wpos;
  } mem_req_t;

endpackage

// File: rtl/umls_mem.sv
module umls_mem (
  input  logic                 clk,
  input  umls_pkg::mem_req_t   req,
  output logic [umls_pkg::KeyWidth-1:0] ls_rdata,
  output logic [umls_pkg::KeyWidth-1:0] uk_rdata,
  output logic [umls_pkg::LenW-1:0]     pt_rdata
);

  logic [umls_pkg::KeyWidth-1:0] list_store [umls_pkg::StoreDepth];
  logic [umls_pkg::KeyWidth-1:0] ukeys [umls_pkg::StoreDepth];
  logic [umls_pkg::LenW-1:0] ptab [umls_pkg::StoreDepth * umls_pkg::MaxLists];

  always_ff @(posedge clk) begin
    if (req.ls_we) list_store[req.ls_addr] <= req.wkey;
    ls_rdata <= list_store[req.ls_addr];
  end

  always_ff @(posedge clk) begin
    if (req.uk_we) ukeys[req.uk_addr] <= req.wkey;
    uk_rdata <= ukeys[req.uk_addr];
  end

  always_ff @(posedge clk) begin
    if (req.pt_we) ptab[req.pt_addr] <= req.wpos;
    pt_rdata <= ptab[req.pt_addr];
  end

endmodule

// File: rtl/umls_seq.sv
module umls_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  umls_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output umls_pkg::out_word_t out_data,
  output umls_pkg::mem_req_t  req,
  input  logic [umls_pkg::KeyWidth-1:0] ls_rdata,
  input  logic [umls_pkg::KeyWidth-1:0] uk_rdata,
  input  logic [umls_pkg::LenW-1:0]     pt_rdata
);

  localparam int KW = umls_pkg::KeyWidth;
  localparam int LW = umls_pkg::LidW;
  localparam int NW = LW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_OUT,
    S_B_RD, S_B_WT, S_B_CMP, S_B_WR, S_B_ADV_RD, S_B_ADV_WT, S_B_ADV,
    S_Q_RD, S_Q_WT, S_Q_CMP, S_Q_PRD, S_Q_PWT, S_Q_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] num_lists_r, num_lists_nxt;
  logic built_r, built_nxt;
  logic [umls_pkg::LenW-1:0] len_r [umls_pkg::MaxLists];
  logic [umls_pkg::LenW-1:0] len_nxt [umls_pkg::MaxLists];
  logic [umls_pkg::LenW-1:0] head_r [umls_pkg::MaxLists];
  logic [umls_pkg::LenW-1:0] head_nxt [umls_pkg::MaxLists];
  logic [umls_pkg::CntW-1:0] ulen_r, ulen_nxt;
  logic [umls_pkg::CntW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LW-1:0] li_r, li_nxt;
  logic any_r, any_nxt;
  logic [KW-1:0] min_r, min_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic out_valid_r, out_valid_nxt;
  umls_pkg::out_word_t out_r, out_nxt;

  logic [NW-1:0] nl;
  logic [umls_pkg::CntW-1:0] mid;
  logic [KW-1:0] ekey, rkey;
  logic [LW-1:0] lid;
  logic last_li;

  always_comb begin
    if (num_lists_r == 4'd0) nl = NW'(1);
    else if (num_lists_r > 4'(umls_pkg::MaxLists)) nl = NW'(umls_pkg::MaxLists);
    else nl = NW'(num_lists_r);
  end

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign ekey = in_data.key ^ {1'b1, {(KW-1){1'b0}}};
  assign lid = in_data.list_id[LW-1:0];
  assign last_li = ({1'b0, li_r} + NW'(1)) == nl;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    req = '0;
    req.wkey = min_r;
    req.ls_addr = {li_r, head_r[li_r][umls_pkg::SlotW-1:0]};
    req.uk_addr = ulen_r[umls_pkg::AddrW-1:0];
    req.pt_addr = {ulen_r[umls_pkg::AddrW-1:0], li_r};
    req.wpos = head_r[li_r];
    case (state_r)
      S_IDLE: begin
        req.ls_addr = {lid, len_r[lid][umls_pkg::SlotW-1:0]};
        req.wkey = ekey;
        req.ls_we = in_valid && in_ready && in_data.opcode == umls_pkg::OP_APPEND
                    && {1'b0, lid} < nl
                    && len_r[lid] < umls_pkg::LenW'(umls_pkg::MaxListLen);
      end
      S_B_WR: begin
        req.uk_we = (li_r == '0);
        req.pt_we = 1'b1;
      end
      // hold the probe address until the compare state sees its word
      S_Q_RD, S_Q_WT: req.uk_addr = mid[umls_pkg::AddrW-1:0];
      S_Q_PRD: req.pt_addr = {lo_r[umls_pkg::AddrW-1:0], li_r};
      default: ;
    endcase
  end

  assign rkey = ls_rdata;

  always_comb begin
    state_nxt = state_r;
    num_lists_nxt = num_lists_r;
    built_nxt = built_r;
    len_nxt = len_r;
    head_nxt = head_r;
    ulen_nxt = ulen_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    li_nxt = li_r;
    any_nxt = any_r;
    min_nxt = min_r;
    key_nxt = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    if (cfg_we) begin
      num_lists_nxt = cfg_wdata;
      built_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        out_nxt = '0;
        out_nxt.last = 1'b1;
        key_nxt = ekey;
        case (in_data.opcode)
          umls_pkg::OP_APPEND: begin
            built_nxt = 1'b0;
            out_nxt.list_no = in_data.list_id;
            if (req.ls_we) begin
              out_nxt.position = 9'(len_r[lid]);
              len_nxt[lid] = len_r[lid] + 1'b1;
            end else begin
              out_nxt.status = umls_pkg::ST_FULL;
            end
            out_valid_nxt = 1'b1;
          end
          umls_pkg::OP_BUILD: begin
            for (int i = 0; i < umls_pkg::MaxLists; i++) head_nxt[i] = '0;
            ulen_nxt = '0;
            li_nxt = '0;
            any_nxt = 1'b0;
            state_nxt = S_B_RD;
          end
          umls_pkg::OP_QUERY: begin
            if (!built_r) begin
              out_nxt.status = umls_pkg::ST_NOT_BUILT;
              out_valid_nxt = 1'b1;
            end else begin
              lo_nxt = '0;
              hi_nxt = ulen_r;
              state_nxt = S_Q_RD;
            end
          end
          umls_pkg::OP_CLEAR: begin
            for (int i = 0; i < umls_pkg::MaxLists; i++) len_nxt[i] = '0;
            ulen_nxt = '0;
            built_nxt = 1'b0;
            out_valid_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      // scan heads for minimum, one list per pass
      S_B_RD: begin
        if (head_r[li_r] < len_r[li_r]) state_nxt = S_B_WT;
        else if (last_li) state_nxt = S_B_CMP;
        else li_nxt = li_r + 1'b1;
      end
      S_B_WT: begin
        if (!any_r || rkey < min_r) min_nxt = rkey;
        any_nxt = 1'b1;
        if (last_li) state_nxt = S_B_CMP;
        else begin
          li_nxt = li_r + 1'b1;
          state_nxt = S_B_RD;
        end
      end
      S_B_CMP: begin
        li_nxt = '0;
        if (!any_r || ulen_r == umls_pkg::CntW'(umls_pkg::StoreDepth)) begin
          built_nxt = 1'b1;
          out_nxt.distinct_count = 12'(ulen_r);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else state_nxt = S_B_WR;
      end
      S_B_WR: state_nxt = S_B_ADV_RD;
      // advance this list past elements equal to min
      S_B_ADV_RD: begin
        if (head_r[li_r] < len_r[li_r]) state_nxt = S_B_ADV_WT;
        else state_nxt = S_B_ADV;
      end
      S_B_ADV_WT: begin
        if (rkey == min_r) begin
          head_nxt[li_r] = head_r[li_r] + 1'b1;
          state_nxt = S_B_ADV_RD;
        end else state_nxt = S_B_ADV;
      end
      S_B_ADV: begin
        if (last_li) begin
          li_nxt = '0;
          any_nxt = 1'b0;
          ulen_nxt = ulen_r + 1'b1;
          state_nxt = S_B_RD;
        end else begin
          li_nxt = li_r + 1'b1;
          state_nxt = S_B_WR;
        end
      end
      S_Q_RD: begin
        if (lo_r < hi_r) state_nxt = S_Q_WT;
        else begin
          out_nxt.status = umls_pkg::ST_NOT_FOUND;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_Q_WT: state_nxt = S_Q_CMP;
      S_Q_CMP: begin
        if (uk_rdata == key_r) begin
          lo_nxt = mid;
          li_nxt = '0;
          state_nxt = S_Q_PRD;
        end else begin
          if (uk_rdata < key_r) lo_nxt = mid + 1'b1;
          else hi_nxt = mid;
          state_nxt = S_Q_RD;
        end
      end
      S_Q_PRD: state_nxt = S_Q_PWT;
      S_Q_PWT: begin
        out_nxt = '0;
        out_nxt.list_no = 3'(li_r);
        out_nxt.position = 9'(pt_rdata);
        out_nxt.last = last_li;
        out_valid_nxt = 1'b1;
        state_nxt = S_Q_EMIT;
      end
      S_Q_EMIT: if (!out_valid_r) begin
        if (out_r.last) state_nxt = S_IDLE;
        else begin
          li_nxt = li_r + 1'b1;
          state_nxt = S_Q_PRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_lists_r <= 4'd8;
      built_r <= 1'b0;
      for (int i = 0; i < umls_pkg::MaxLists; i++) len_r[i] <= '0;
      ulen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      num_lists_r <= num_lists_nxt;
      built_r <= built_nxt;
      len_r <= len_nxt;
      ulen_r <= ulen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    li_r <= li_nxt;
    any_r <= any_nxt;
    min_r <= min_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_CMP) |-> (lo_r < hi_r)) else $error("search window empty");
  a_ulen_max: assert property (@(posedge clk) disable iff (!rst_n)
    ulen_r <= umls_pkg::CntW'(umls_pkg::StoreDepth)) else $error("table overrun");

endmodule

// File: rtl/unified_index_multi_list_search_top.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data (umls_pkg::in_word_t)
// out     | out | out_valid/out_ready | out_data (umls_pkg::out_word_t)
// cfg     | in  | cfg_we              | cfg_wdata (num_lists)
// Append, clear and not-built query: answered from the idle state, plus output handoff.
// Query: a binary search of the key memory (read, wait and compare states per probe),
// then one position-table read per list word emitted; one memory read port sets the pace.
// Build: a read of each list head scanned plus per-element advance reads,
// repeated for every distinct key.
// Reset is synchronous; list, key and position memories are not cleared.
module unified_index_multi_list_search_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  umls_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output umls_pkg::out_word_t out_data
);

  umls_pkg::mem_req_t req;
  logic [umls_pkg::KeyWidth-1:0] ls_rdata, uk_rdata;
  logic [umls_pkg::LenW-1:0] pt_rdata;

  umls_seq u_seq (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .req, .ls_rdata, .uk_rdata, .pt_rdata
  );

  umls_mem u_mem (.clk, .req, .ls_rdata, .uk_rdata, .pt_rdata);

endmodule

// File: tb/sv/unified_index_multi_list_search_top_tb.sv
module unified_index_multi_list_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  umls_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  umls_pkg::out_word_t out_data;

  unified_index_multi_list_search_top i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  umls_pkg::in_word_t  word_q[$];
  umls_pkg::out_word_t result_q[$];
  int        err_cnt = 0;
  bit        in_took = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        calm = 1'b0;
  bit        hold_start = 1'b0;
  int        hold_left = 0;

  // shadow of the block state
  logic signed [31:0] list_key[umls_pkg::MaxLists][umls_pkg::MaxListLen];
  int                 list_len[umls_pkg::MaxLists];
  logic signed [31:0] uni_key[umls_pkg::StoreDepth];
  int                 pos_tab[umls_pkg::StoreDepth][umls_pkg::MaxLists];
  int                 uni_len;
  bit                 built;
  logic [3:0]         nlists_reg;

  function automatic int lists_in_use();
    if (nlists_reg == 0) return 1;
    if (nlists_reg > umls_pkg::MaxLists) return umls_pkg::MaxLists;
    return nlists_reg;
  endfunction

  function automatic umls_pkg::out_word_t mk(umls_pkg::status_t st, int lst, int pos,
                                             int cnt, bit lst_last);
    umls_pkg::out_word_t r;
    r.status = st;
    r.list_no = lst[2:0];
    r.position = pos[8:0];
    r.distinct_count = cnt[11:0];
    r.last = lst_last;
    return r;
  endfunction

  task automatic merge_lists();
    int head[umls_pkg::MaxLists];
    int nl, y;
    bit any;
    logic signed [31:0] mn;
    nl = lists_in_use();
    y = 0;
    foreach (head[i]) head[i] = 0;
    forever begin
      any = 1'b0;
      mn = '0;
      for (int i = 0; i < nl; i++)
        if (head[i] < list_len[i]) begin
          if (!any || list_key[i][head[i]] < mn) mn = list_key[i][head[i]];
          any = 1'b1;
        end
      if (!any || y >= umls_pkg::StoreDepth) break;
      uni_key[y] = mn;
      for (int i = 0; i < nl; i++) begin
        pos_tab[y][i] = head[i];
        while (head[i] < list_len[i] && list_key[i][head[i]] == mn) head[i]++;
      end
      y++;
    end
    uni_len = y;
    built = 1'b1;
  endtask

  task automatic predict_word(umls_pkg::in_word_t w);
    int nl, lo, hi, mid, id;
    nl = lists_in_use();
    id = w.list_id;
    case (umls_pkg::opcode_t'(w.opcode))
      umls_pkg::OP_APPEND: begin
        built = 1'b0;
        if (id >= nl || list_len[id] >= umls_pkg::MaxListLen) begin
          result_q.push_back(mk(umls_pkg::ST_FULL, id, 0, 0, 1'b1));
        end else begin
          list_key[id][list_len[id]] = w.key;
          result_q.push_back(mk(umls_pkg::ST_OK, id, list_len[id], 0, 1'b1));
          list_len[id]++;
        end
      end
      umls_pkg::OP_BUILD: begin
        merge_lists();
        result_q.push_back(mk(umls_pkg::ST_OK, 0, 0, uni_len, 1'b1));
      end
      umls_pkg::OP_QUERY: begin
        if (!built) begin
          result_q.push_back(mk(umls_pkg::ST_NOT_BUILT, 0, 0, 0, 1'b1));
          return;
        end
        lo = 0;
        hi = uni_len;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (uni_key[mid] == w.key) begin
            for (int i = 0; i < nl; i++)
              result_q.push_back(mk(umls_pkg::ST_OK, i, pos_tab[mid][i], 0, i + 1 == nl));
            return;
          end
          if (uni_key[mid] < w.key) lo = mid + 1;
          else hi = mid;
        end
        result_q.push_back(mk(umls_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1));
      end
      default: begin
        foreach (list_len[i]) list_len[i] = 0;
        uni_len = 0;
        built = 1'b0;
        result_q.push_back(mk(umls_pkg::ST_OK, 0, 0, 0, 1'b1));
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input side: accept + predict at rising edge, drive at falling edge
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_we) begin
        nlists_reg = cfg_wdata;
        built = 1'b0;
      end
      if (in_valid && in_ready) begin
        predict_word(in_data);
      end
    end else begin
      foreach (list_len[i]) list_len[i] = 0;
      uni_len = 0;
      built = 1'b0;
      nlists_reg = 4'd8;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
      recv_gap <= pick_gap();
    end
  end

  task automatic report(string what, int got, int want);
    err_cnt++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    umls_pkg::out_word_t ex;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report("unexpected word", out_data.status, -1);
      end else begin
        ex = result_q.pop_front();
        if (out_data.status != ex.status) report("status", out_data.status, ex.status);
        if (out_data.list_no != ex.list_no) report("list_no", out_data.list_no, ex.list_no);
        if (out_data.position != ex.position)
          report("position", out_data.position, ex.position);
        if (out_data.distinct_count != ex.distinct_count)
          report("distinct_count", out_data.distinct_count, ex.distinct_count);
        if (out_data.last != ex.last) report("last", out_data.last, ex.last);
      end
    end
  end

  task automatic send(umls_pkg::opcode_t op, int id, logic signed [31:0] k);
    umls_pkg::in_word_t w;
    w.opcode = op;
    w.list_id = id[2:0];
    w.key = k;
    word_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_lists(int v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // clear, load mostly ascending lists with shared keys, build, then mostly queries
  task automatic index_round(int n_app, int n_qry);
    logic signed [31:0] tail[umls_pkg::MaxLists];
    logic signed [31:0] seen[$];
    logic signed [31:0] base, k;
    int id;
    base = $urandom;
    foreach (tail[i]) tail[i] = base;
    send(umls_pkg::OP_CLEAR, $urandom_range(0, 7), $urandom);
    for (int n = 0; n < n_app; n++) begin
      id = $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0) k = $urandom;
      else begin
        k = tail[id] + $urandom_range(0, 2);
        tail[id] = k;
      end
      seen.push_back(k);
      send(umls_pkg::OP_APPEND, id, k);
    end
    send(umls_pkg::OP_BUILD, $urandom_range(0, 7), $urandom);
    for (int n = 0; n < n_qry; n++) begin
      case ($urandom_range(0, 19))
        0: send(umls_pkg::opcode_t'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom);
        1: send(umls_pkg::OP_QUERY, $urandom_range(0, 7), $urandom);
        2: send(umls_pkg::OP_QUERY, 0, base - 1);
        default: send(umls_pkg::OP_QUERY, $urandom_range(0, 7),
                      seen[$urandom_range(0, seen.size() - 1)]);
      endcase
    end
  endtask

  initial begin
    logic signed [31:0] k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty index, extremes, duplicates, not-built, disabled list
    send(umls_pkg::OP_QUERY, 0, 0);
    send(umls_pkg::OP_BUILD, 0, 0);
    send(umls_pkg::OP_QUERY, 7, 32'sh7fffffff);
    send(umls_pkg::OP_APPEND, 0, 32'sh80000000);
    send(umls_pkg::OP_APPEND, 0, 32'sh80000000);
    send(umls_pkg::OP_APPEND, 7, 32'sh7fffffff);
    send(umls_pkg::OP_APPEND, 1, 0);
    send(umls_pkg::OP_APPEND, 1, 5);
    send(umls_pkg::OP_APPEND, 2, 5);
    send(umls_pkg::OP_APPEND, 2, 3);
    send(umls_pkg::OP_QUERY, 1, 5);
    send(umls_pkg::OP_BUILD, 5, -1);
    send(umls_pkg::OP_QUERY, 0, 32'sh80000000);
    send(umls_pkg::OP_QUERY, 0, 5);
    send(umls_pkg::OP_QUERY, 0, 32'sh7fffffff);
    send(umls_pkg::OP_QUERY, 0, 4);
    send(umls_pkg::OP_QUERY, 0, -1);
    write_lists(3);
    send(umls_pkg::OP_APPEND, 5, 1);
    send(umls_pkg::OP_BUILD, 0, 0);
    send(umls_pkg::OP_QUERY, 0, 5);
    write_lists(0);
    send(umls_pkg::OP_APPEND, 1, 9);
    send(umls_pkg::OP_BUILD, 0, 0);
    send(umls_pkg::OP_QUERY, 0, 32'sh80000000);
    send(umls_pkg::OP_CLEAR, 7, -1);
    send(umls_pkg::OP_QUERY, 0, 0);

    // fill one list past its end
    write_lists(15);
    calm = 1'b1;
    k = -300;
    for (int n = 0; n < 257; n++) begin
      k = k + $urandom_range(0, 3);
      send(umls_pkg::OP_APPEND, 4, k);
    end
    send(umls_pkg::OP_BUILD, 0, 0);
    for (int n = 0; n < 8; n++) send(umls_pkg::OP_QUERY, 0, -300 + $urandom_range(0, 40));
    wait_idle();
    calm = 1'b0;

    write_lists(8);
    hold_start = 1'b1;
    index_round(40, 25);
    write_lists(1);
    index_round(15, 15);
    write_lists(5);
    index_round(30, 20);
    write_lists(15);
    index_round(30, 30);
    write_lists(2);
    index_round(20, 20);

    wait_idle();
    repeat (50) @(posedge clk);
    if (err_cnt == 0) $display("unified_index_multi_list_search_top verification clean");
    else $display("unified_index_multi_list_search_top verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("unified_index_multi_list_search_top verification failed");
    $finish;
  end
endmodule

// File: unified_index_multi_list_search_top.f
rtl/umls_pkg.sv
rtl/umls_mem.sv
rtl/umls_seq.sv
rtl/unified_index_multi_list_search_top.sv
tb/sv/unified_index_multi_list_search_top_tb.sv
